// ----- src/sync_length_checksum_deframer_top_assert.svh -----
// -----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// -----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define SLCD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// next-cycle implication
`define SLCD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

// ----- src/slcd_pkg.sv -----
// -----------------------------------------------------------------------------
// Deframer package
// Shared widths, constants, codes and types of the sync/length/checksum deframer.
// -----------------------------------------------------------------------------
package slcd_pkg;

   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned NUM_CODE_REGS  = 4;
   localparam int unsigned MATCH_SLOTS    = 4;
   localparam int unsigned CSR_INDEX_W    = 3;
   localparam int unsigned SLOT_W         = 2;
   localparam int unsigned KIND_W         = 2;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
   localparam logic [BYTE_W-1:0] SUM_SEED  = 8'hFF;
   localparam int unsigned       REPLY_BIT = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_CSUM_ERR = 2'd2,
      KIND_SKIPPED  = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MATCH_CODE_0 = 3'd0,
      REG_MATCH_CODE_1 = 3'd1,
      REG_MATCH_CODE_2 = 3'd2,
      REG_MATCH_CODE_3 = 3'd3,
      REG_MATCH_ENABLE = 3'd4
   } csr_index_type;

   typedef logic [NUM_CODE_REGS-1:0][BYTE_W-1:0] code_array_type;

   typedef struct packed {
      code_array_type            codes;
      logic [NUM_CODE_REGS-1:0]  enable;
   } match_cfg_type;

   typedef struct packed {
      kind_type                  kind;
      logic [BYTE_W-1:0]         data_byte;
      logic [BYTE_W-1:0]         frame_len;
      logic                      hit;
      logic [SLOT_W-1:0]         hit_slot;
      logic                      reply_bit_missing;
   } result_type;

endpackage

// ----- src/slcd_interfaces.sv -----
// -----------------------------------------------------------------------------
// Deframer channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// -----------------------------------------------------------------------------
interface slcd_req_if;
   import slcd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcd_rsp_if;
   import slcd_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] data_byte;
   logic [BYTE_W-1:0] frame_len;
   logic              hit;
   logic [SLOT_W-1:0] hit_slot;
   logic              reply_bit_missing;

   modport source (output valid, output kind, output data_byte, output frame_len,
                   output hit, output hit_slot, output reply_bit_missing, input ready);
   modport sink   (input valid, input kind, input data_byte, input frame_len,
                   input hit, input hit_slot, input reply_bit_missing, output ready);
endinterface

interface slcd_csr_if;
   import slcd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [BYTE_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/slcd_csr.sv -----
// -----------------------------------------------------------------------------
// Deframer match registers
// Holds the four match codes and the slot enable mask; always ready.
// -----------------------------------------------------------------------------
module slcd_csr (
   input  logic                   clock,
   input  logic                   reset,
   slcd_csr_if.sink               csr_chan,
   output slcd_pkg::match_cfg_type cfg
);
   import slcd_pkg::*;

   match_cfg_type cfg_ff;
   match_cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            REG_MATCH_CODE_0: cfg_in.codes[0] = csr_chan.data;
            REG_MATCH_CODE_1: cfg_in.codes[1] = csr_chan.data;
            REG_MATCH_CODE_2: cfg_in.codes[2] = csr_chan.data;
            REG_MATCH_CODE_3: cfg_in.codes[3] = csr_chan.data;
            REG_MATCH_ENABLE: cfg_in.enable   = csr_chan.data[NUM_CODE_REGS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/slcd_parser.sv -----
// -----------------------------------------------------------------------------
// Deframer parser
// Frame state machine: sync hunt, command, length, payload and checksum phases.
// Gives the result of the byte in the input register; state moves on step.
// -----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_top_assert.svh"

module slcd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [slcd_pkg::BYTE_W-1:0] rx_byte,
   input  slcd_pkg::match_cfg_type     cfg,
   output logic                        has_result,
   output slcd_pkg::result_type        result
);
   import slcd_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_CMD  = 3'd1,
      PH_LEN  = 3'd2,
      PH_PAY  = 3'd3,
      PH_CHK  = 3'd4
   } phase_type;

   phase_type         phase_ff,   phase_in;
   logic [BYTE_W-1:0] sum_ff,     sum_in;
   logic [BYTE_W-1:0] command_ff, command_in;
   logic [BYTE_W-1:0] length_ff,  length_in;
   logic [BYTE_W-1:0] left_ff,    left_in;

   logic              hit;
   logic [SLOT_W-1:0] hit_slot;
   logic [BYTE_W-1:0] left_dec;
   logic              rbm;

   // lowest enabled slot wins
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = NUM_CODE_REGS - 1; i >= 0; i--) begin
         if ((i < MATCH_SLOTS) && cfg.enable[i] && (cfg.codes[i] == command_ff)) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(i);
         end
      end
   end

   assign left_dec = left_ff - 8'd1;
   assign rbm      = ~command_ff[REPLY_BIT];

   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      command_in = command_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      has_result = 1'b0;
      result     = '{kind: KIND_PAYLOAD, data_byte: rx_byte, frame_len: length_ff,
                     hit: 1'b0, hit_slot: '0, reply_bit_missing: 1'b0};
      unique case (phase_ff)
         PH_CMD: begin
            command_in = rx_byte;
            sum_in     = sum_ff + rx_byte;
            phase_in   = PH_LEN;
         end
         PH_LEN: begin
            length_in = rx_byte;
            left_in   = rx_byte;
            sum_in    = sum_ff + rx_byte;
            phase_in  = (rx_byte == '0) ? PH_CHK : PH_PAY;
         end
         PH_PAY: begin
            sum_in     = sum_ff + rx_byte;
            left_in    = left_dec;
            has_result = 1'b1;
            if (left_dec == '0) begin
               phase_in = PH_CHK;
            end
         end
         PH_CHK: begin
            phase_in                 = PH_HUNT;
            has_result               = 1'b1;
            result.data_byte         = command_ff;
            result.reply_bit_missing = rbm;
            if (rx_byte != ~sum_ff) begin
               result.kind = KIND_CSUM_ERR;
            end else begin
               result.kind     = KIND_GOOD;
               result.hit      = hit;
               result.hit_slot = hit_slot;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == SYNC_BYTE) begin
               sum_in     = SUM_SEED + rx_byte;
               command_in = '0;
               length_in  = '0;
               left_in    = '0;
               phase_in   = PH_CMD;
            end else begin
               has_result       = 1'b1;
               result.kind      = KIND_SKIPPED;
               result.frame_len = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         sum_ff     <= '0;
         command_ff <= '0;
         length_ff  <= '0;
         left_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         sum_ff     <= sum_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         left_ff    <= left_in;
      end
   end

   `SLCD_ASSERT_NOW(a_pay_has_left, phase_ff == PH_PAY, left_ff != '0)
   `SLCD_ASSERT_NOW(a_pay_left_bound, phase_ff == PH_PAY, left_ff <= length_ff)
   `SLCD_ASSERT_NEXT(a_sync_to_cmd,
      step && (phase_ff == PH_HUNT) && (rx_byte == SYNC_BYTE), phase_ff == PH_CMD)

endmodule

// ----- src/sync_length_checksum_deframer_top.sv -----
// -----------------------------------------------------------------------------
// Sync/length/checksum deframer
// Takes one received byte per transfer and returns at most one result per byte.
// -----------------------------------------------------------------------------
// A byte is taken every cycle while the result side keeps up: it passes an
// input register, the frame state machine and a result register, and the
// rate is one byte per clock unless a held result stalls the input.
// Sync, command and length bytes give no result. Match registers are written
// through the csr channel, which is always ready; write them only while idle.
`include "sync_length_checksum_deframer_top_assert.svh"

module sync_length_checksum_deframer_top (
   input  logic       clock,
   input  logic       reset,
   slcd_req_if.sink   req_chan,
   slcd_rsp_if.source rsp_chan,
   slcd_csr_if.sink   csr_chan
);
   import slcd_pkg::*;

   match_cfg_type     cfg;
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   result_type        out_ff;
   logic              has_result;
   result_type        result;
   logic              out_free;
   logic              step;

   slcd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   slcd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (result)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && (!has_result || out_free);
   assign req_chan.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            out_valid_ff <= step && has_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (out_free && step && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.kind              = out_ff.kind;
   assign rsp_chan.data_byte         = out_ff.data_byte;
   assign rsp_chan.frame_len         = out_ff.frame_len;
   assign rsp_chan.hit               = out_ff.hit;
   assign rsp_chan.hit_slot          = out_ff.hit_slot;
   assign rsp_chan.reply_bit_missing = out_ff.reply_bit_missing;

   `SLCD_ASSERT_NOW(a_hit_only_good, out_valid_ff && out_ff.hit, out_ff.kind == KIND_GOOD)
   `SLCD_ASSERT_NOW(a_slot_zero_no_hit, out_valid_ff && !out_ff.hit, out_ff.hit_slot == '0)
   `SLCD_ASSERT_NOW(a_skip_clean, out_valid_ff && (out_ff.kind == KIND_SKIPPED),
      (out_ff.frame_len == '0) && !out_ff.reply_bit_missing)
   `SLCD_ASSERT_NEXT(a_held_item, in_valid_ff && !step, in_valid_ff && $stable(in_byte_ff))

endmodule
